// File: hw/rtl/wsdf_pkg.sv
// Package for the WebSocket frame deframer: parse phase codes, header
// constants and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wsdf_pkg;

   // Parse phase, one-hot
   typedef enum logic [4:0] {
      PH_HDR1    = 5'b00001,
      PH_HDR2    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_MASK    = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   localparam logic [3:0] OP_CONT = 4'h0;
   localparam logic [3:0] OP_TEXT = 4'h1;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   localparam logic [3:0] EXT16_BYTES = 4'd2;
   localparam logic [3:0] EXT64_BYTES = 4'd8;
   localparam logic [3:0] KEY_BYTES   = 4'd4;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       message_end;
   } result_type;

endpackage : wsdf_pkg

`default_nettype wire

// File: hw/rtl/websocket_frame_deframer_core.sv
// WebSocket frame deframer top level: header parse, payload count and
// result register with skid stage. Depends on wsdf_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   req channel: one received stream byte per item (req_rx_byte). An item
//   is taken at a clock edge with req_valid high and req_stall low.
//   rsp channel: zero or one result item per input item. Payload bytes of
//   text messages (including continuation fragments) come out with
//   rsp_has_byte set; the last byte of a FIN frame also sets
//   rsp_message_end. A zero-length FIN text frame yields an end-only item.
//   Binary, control and stray continuation frames produce nothing.
// Timing
//   One item per cycle sustained while req_stall is low. Results are
//   registered (result register, or skid while stalled). The per-byte work
//   is one header/state update plus a LENGTH_BITS-wide decrement and compare
//   on the payload counter, all between the parser state and the result register.
// Stall
//   A result register plus a one-deep skid register sit on the output, so
//   a byte is still taken in the cycle the receiver first stalls. req_stall
//   rises only while the skid register is occupied.
// Reset
//   Synchronous, active high: parser returns to the first header byte, no
//   message open, both result registers empty.
module websocket_frame_deframer_core
   import wsdf_pkg::*;
#(
   parameter int LENGTH_BITS = 64   // payload length counter width, 16..64
) (
   input  wire logic       clock,
   input  wire logic       reset,

   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_rx_byte,

   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_payload_byte,
   output      logic       rsp_has_byte,
   output      logic       rsp_message_end
);

   localparam logic [LENGTH_BITS-1:0] LEN_ZERO = '0;
   localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

   // Parser state
   phase_type              phase_ff, phase_in;
   logic                   fin_ff, fin_in;
   logic [3:0]             kind_ff, kind_in;
   logic                   mask_ff, mask_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic                   in_text_ff, in_text_in;

   // Output side
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff, skid_data_in;

   logic       accept;
   logic       res_valid;
   result_type res;
   logic       is_msg;
   logic       len_done;
   logic       hdr_done;
   logic       out_free;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;

   // Frame carries message data: text, or continuation of an open message
   assign is_msg = (kind_ff == OP_TEXT) || ((kind_ff == OP_CONT) && in_text_ff);

   // Per-byte parse
   always_comb begin
      phase_in   = phase_ff;
      fin_in     = fin_ff;
      kind_in    = kind_ff;
      mask_in    = mask_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      in_text_in = in_text_ff;
      res_valid  = 1'b0;
      res        = '0;
      len_done   = 1'b0;
      hdr_done   = 1'b0;

      case (phase_ff)
         PH_HDR2: begin
            mask_in = req_rx_byte[7];
            rem_in  = LEN_ZERO;
            if (req_rx_byte[6:0] == LEN7_EXT16) begin
               cnt_in   = EXT16_BYTES;
               phase_in = PH_EXTLEN;
            end else if (req_rx_byte[6:0] == LEN7_EXT64) begin
               cnt_in   = EXT64_BYTES;
               phase_in = PH_EXTLEN;
            end else begin
               rem_in   = {{(LENGTH_BITS-7){1'b0}}, req_rx_byte[6:0]};
               len_done = 1'b1;
            end
         end
         PH_EXTLEN: begin
            // big-endian shift-in; upper bytes fall off the top
            rem_in = {rem_ff[LENGTH_BITS-9:0], req_rx_byte};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_in == 4'd0) begin
               len_done = 1'b1;
            end
         end
         PH_MASK: begin
            cnt_in = cnt_ff - 4'd1;
            if (cnt_in == 4'd0) begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            rem_in = rem_ff - LEN_ONE;
            if (rem_ff == LEN_ONE) begin
               phase_in = PH_HDR1;
            end
            if (is_msg) begin
               res_valid        = 1'b1;
               res.payload_byte = req_rx_byte;
               res.has_byte     = 1'b1;
               if (rem_ff == LEN_ONE) begin
                  if (fin_ff) begin
                     in_text_in      = 1'b0;
                     res.message_end = 1'b1;
                  end else begin
                     in_text_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            // first header byte; stray phase codes land here too
            fin_in   = req_rx_byte[7];
            kind_in  = req_rx_byte[3:0];
            cnt_in   = 4'd0;
            phase_in = PH_HDR2;
         end
      endcase

      // Length known: masking key next, or header complete
      if (len_done) begin
         if (mask_in) begin
            cnt_in   = KEY_BYTES;
            phase_in = PH_MASK;
         end else begin
            hdr_done = 1'b1;
         end
      end

      // Header complete: zero-length frames finish right here
      if (hdr_done) begin
         if (rem_in != LEN_ZERO) begin
            phase_in = PH_PAYLOAD;
         end else begin
            phase_in = PH_HDR1;
            if (is_msg) begin
               if (fin_ff) begin
                  in_text_in      = 1'b0;
                  res_valid       = 1'b1;
                  res.message_end = 1'b1;
               end else begin
                  in_text_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HDR1;
         fin_ff     <= 1'b0;
         kind_ff    <= 4'd0;
         mask_ff    <= 1'b0;
         cnt_ff     <= 4'd0;
         rem_ff     <= LEN_ZERO;
         in_text_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         fin_ff     <= fin_in;
         kind_ff    <= kind_in;
         mask_ff    <= mask_in;
         cnt_ff     <= cnt_in;
         rem_ff     <= rem_in;
         in_text_ff <= in_text_in;
      end
   end

   // Result register + skid: skid fills only when the result register is
   // held by a stall; it drains first when the register frees up.
   assign out_free = ~out_valid_ff | ~rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept & res_valid;
            out_data_in  = res;
         end
      end else if (accept & res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_payload_byte = out_data_ff.payload_byte;
   assign rsp_has_byte     = out_data_ff.has_byte;
   assign rsp_message_end  = out_data_ff.message_end;

endmodule : websocket_frame_deframer_core

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for websocket_frame_deframer_core: frame stimulus,
// an in-bench deframing predictor and a result checker. Depends on wsdf_pkg.
`timescale 1ns / 1ps

module tb_top
   import wsdf_pkg::*;
();

   localparam int LEN_W = 64;

   // opcodes used by the stimulus besides the two in the package
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} length_form_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_byte;
   logic       rsp_message_end;

   websocket_frame_deframer_core #(.LENGTH_BITS(LEN_W)) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_message_end  (rsp_message_end)
   );

   always #5 clock = ~clock;

   // Run limit, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   int unsigned send_idle_pct  = 0;
   int unsigned stall_pct      = 0;
   logic        hold_on        = 1'b0;   // long receiver hold-off
   int unsigned bytes_accepted = 0;
   int unsigned fail_count     = 0;

   result_type pending_results[$];

   // ---------------------------------------------------------------
   // Deframing predictor: own copy of the parser state
   // ---------------------------------------------------------------
   phase_type        rx_phase     = PH_HDR1;
   logic             rx_fin       = 1'b0;
   logic [3:0]       rx_opcode    = 4'h0;
   logic             rx_masked    = 1'b0;
   logic [3:0]       hdr_left     = 4'd0;
   logic [LEN_W-1:0] payload_left = '0;
   logic             text_open    = 1'b0;

   function automatic logic in_message_frame();
      return rx_opcode == OP_TEXT || (rx_opcode == OP_CONT && text_open);
   endfunction

   task automatic expect_result(input logic [7:0] b, input logic has, input logic fin_mark);
      result_type r;
      r.payload_byte  = b;
      r.has_byte      = has;
      r.message_end   = fin_mark;
      pending_results = {pending_results, r};
   endtask

   // header complete; a zero-length message frame ends here
   task automatic finish_header();
      if (payload_left != '0) begin
         rx_phase = PH_PAYLOAD;
      end else begin
         rx_phase = PH_HDR1;
         if (in_message_frame()) begin
            if (rx_fin) begin
               text_open = 1'b0;
               expect_result(8'h00, 1'b0, 1'b1);
            end else begin
               text_open = 1'b1;
            end
         end
      end
   endtask

   task automatic finish_length();
      if (rx_masked) begin
         hdr_left = KEY_BYTES;
         rx_phase = PH_MASK;
      end else begin
         finish_header();
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic msg;
      logic last;
      case (rx_phase)
         PH_HDR2: begin
            rx_masked    = b[7];
            payload_left = '0;
            if (b[6:0] == LEN7_EXT16) begin
               hdr_left = EXT16_BYTES;
               rx_phase = PH_EXTLEN;
            end else if (b[6:0] == LEN7_EXT64) begin
               hdr_left = EXT64_BYTES;
               rx_phase = PH_EXTLEN;
            end else begin
               payload_left = LEN_W'(b[6:0]);
               finish_length();
            end
         end
         PH_EXTLEN: begin
            payload_left = {payload_left[LEN_W-9:0], b};
            hdr_left     = hdr_left - 4'd1;
            if (hdr_left == 4'd0) finish_length();
         end
         PH_MASK: begin
            hdr_left = hdr_left - 4'd1;
            if (hdr_left == 4'd0) finish_header();
         end
         PH_PAYLOAD: begin
            msg          = in_message_frame();
            payload_left = payload_left - 1'b1;
            last         = (payload_left == '0);
            if (last) rx_phase = PH_HDR1;
            if (msg) begin
               if (last && rx_fin) begin
                  text_open = 1'b0;
                  expect_result(b, 1'b1, 1'b1);
               end else begin
                  if (last) text_open = 1'b1;
                  expect_result(b, 1'b1, 1'b0);
               end
            end
         end
         default: begin
            rx_fin    = b[7];
            rx_opcode = b[3:0];
            hdr_left  = 4'd0;
            rx_phase  = PH_HDR2;
         end
      endcase
   endtask

   // ---------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
      fail_count++;
   endtask

   // takes each result item, then picks the stall for the next edge
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_payload_byte, 8'h00);
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", rsp_payload_byte, want.payload_byte);
            if (rsp_has_byte !== want.has_byte)
               report_mismatch("has_byte", 8'(rsp_has_byte), 8'(want.has_byte));
            if (rsp_message_end !== want.message_end)
               report_mismatch("message_end", 8'(rsp_message_end), 8'(want.message_end));
         end
      end
      rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   // offer one byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      deframe_byte(b);
      bytes_accepted++;
   endtask

   task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opcode,
                             input logic masked, input int unsigned len,
                             input length_form_type form);
      logic [63:0] len64;
      logic [6:0]  len7;
      len64 = 64'(len);
      case (form)
         FORM_EXT16: len7 = LEN7_EXT16;
         FORM_EXT64: len7 = LEN7_EXT64;
         default:    len7 = len64[6:0];
      endcase
      send_byte({fin, rsv, opcode});
      send_byte({masked, len7});
      if (form == FORM_EXT16) begin
         send_byte(len64[15:8]);
         send_byte(len64[7:0]);
      end else if (form == FORM_EXT64) begin
         for (int i = 7; i >= 0; i--) send_byte(len64[i*8 +: 8]);
      end
      if (masked) repeat (4) send_byte(8'($urandom));
      repeat (len) send_byte(8'($urandom));
   endtask

   // random byte; extended length high bytes kept zero so lengths stay short
   task automatic send_noise_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (rx_phase == PH_EXTLEN && hdr_left > 4'd1) b = 8'h00;
      send_byte(b);
   endtask

   task automatic send_random_frame();
      logic [3:0]      op;
      int unsigned     len;
      int unsigned     pick;
      length_form_type form;
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_TEXT;
      else if (pick < 65) op = OP_CONT;
      else                op = 4'($urandom);
      pick = $urandom_range(99);
      if (pick < 70) begin
         form = FORM_SHORT;
         len  = $urandom_range(12);
      end else if (pick < 85) begin
         form = FORM_SHORT;
         len  = $urandom_range(125);
      end else if (pick < 95) begin
         form = FORM_EXT16;
         len  = $urandom_range(300);
      end else begin
         form = FORM_EXT64;
         len  = $urandom_range(40);
      end
      send_frame($urandom_range(99) < 60, 3'($urandom), op, 1'($urandom), len, form);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed_frames();
      send_frame(1'b1, 3'b000, OP_TEXT,   1'b0, 0,   FORM_SHORT);  // empty, end-only
      send_frame(1'b1, 3'b000, OP_TEXT,   1'b1, 1,   FORM_SHORT);  // masked single byte
      send_frame(1'b1, 3'b111, OP_TEXT,   1'b0, 3,   FORM_SHORT);  // RSV bits ignored
      send_frame(1'b1, 3'b000, OP_TEXT,   1'b1, 0,   FORM_EXT16);  // empty behind key
      send_frame(1'b1, 3'b000, OP_TEXT,   1'b0, 0,   FORM_EXT64);
      send_frame(1'b1, 3'b000, OP_TEXT,   1'b0, 2,   FORM_EXT64);
      send_frame(1'b1, 3'b000, OP_TEXT,   1'b1, 20,  FORM_EXT16);
      send_frame(1'b1, 3'b000, OP_BINARY, 1'b1, 3,   FORM_SHORT);  // silent
      send_frame(1'b1, 3'b000, OP_CONT,   1'b0, 2,   FORM_SHORT);  // stray continuation
   endtask

   task automatic test_fragmentation();
      // control frames between fragments, text frame continuing the message
      send_frame(1'b0, 3'b000, OP_TEXT,   1'b0, 2, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_PING,   1'b1, 1, FORM_SHORT);
      send_frame(1'b0, 3'b000, OP_CONT,   1'b0, 0, FORM_SHORT);
      send_frame(1'b0, 3'b000, OP_TEXT,   1'b0, 1, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_PONG,   1'b0, 0, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_CONT,   1'b1, 2, FORM_SHORT);
      // empty fragments: end-only on the final one
      send_frame(1'b0, 3'b000, OP_TEXT,   1'b0, 0, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_CONT,   1'b0, 0, FORM_SHORT);
      // binary and close inside an open message leave it open
      send_frame(1'b0, 3'b000, OP_TEXT,   1'b1, 3, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_BINARY, 1'b0, 2, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_CLOSE,  1'b0, 2, FORM_SHORT);
      send_frame(1'b1, 3'b000, OP_CONT,   1'b0, 1, FORM_SHORT);
   endtask

   task automatic test_all_opcodes();
      for (int op = 0; op < 16; op++)
         send_frame(1'b1, 3'b000, 4'(op), 1'(op), 2, FORM_SHORT);
   endtask

   // mostly well-formed frames, some noise bursts followed by a resync
   task automatic test_random_stream(input int unsigned target);
      int unsigned start;
      start = bytes_accepted;
      while (bytes_accepted - start < target) begin
         if ($urandom_range(99) < 80) begin
            send_random_frame();
         end else begin
            repeat ($urandom_range(1, 12)) send_noise_byte();
            while (rx_phase != PH_HDR1) send_noise_byte();
         end
      end
   endtask

   // receiver holds off for a long stretch while bytes keep coming
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      fork
         begin
            hold_on <= 1'b1;
            repeat (300) @(posedge clock);
            hold_on <= 1'b0;
         end
         repeat (4) send_frame(1'b1, 3'b000, OP_TEXT, 1'b0, 10, FORM_SHORT);
      join
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_fragmentation();
      test_all_opcodes();

      send_idle_pct = 0;  stall_pct = 0;  test_random_stream(25);
      send_idle_pct = 52; stall_pct = 0;  test_random_stream(25);
      send_idle_pct = 0;  stall_pct = 52; test_random_stream(25);
      send_idle_pct = 28; stall_pct = 28; test_random_stream(25);

      test_backpressure();

      req_valid <= 1'b0;
      stall_pct = 0;
      for (int i = 0; i < 5000 && pending_results.size() != 0; i++) @(posedge clock);
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results never delivered", 8'(pending_results.size()), 8'h00);

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
